// ===== design/vmbl_pkg.sv =====
// ----------------------------------------------------------------------------
// vmbl_pkg: shared types and constants for the fuel-map learner
// Table geometry, request codes, register indexes and payload structs.
// ----------------------------------------------------------------------------
package vmbl_pkg;

  localparam int TableCols = 19;
  localparam int TableRows = 11;
  localparam int TableSize = TableRows * TableCols;
  localparam int IdxW      = $clog2(TableSize);

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [2:0] REG_LEARN_EN = 3'd0;
  localparam logic [2:0] REG_RATIO_LO = 3'd1;
  localparam logic [2:0] REG_RATIO_HI = 3'd2;
  localparam logic [2:0] REG_CELL_MIN = 3'd3;
  localparam logic [2:0] REG_CELL_MAX = 3'd4;
  localparam logic [2:0] REG_HOLDOFF  = 3'd5;

  localparam logic [15:0] DivNumer = 16'd32027;
  localparam logic [8:0]  DivBias  = 9'd125;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] load_axis;
    logic [15:0] rpm_axis;
    logic        closed_loop;
    logic [15:0] o2_trim;
    logic [7:0]  rear_o2_adc;
    logic [7:0]  ratio_measured;
    logic [7:0]  rpm_code;
    logic [7:0]  purge_duty;
    logic        fuel_cut_or_fault;
    logic [7:0]  entry_index;
    logic [15:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        read_value;
    logic [3:0]         cells_updated;
    logic signed [15:0] correction;
    logic [8:0]         sensor_ratio;
    logic [7:0]         holdoff_timer;
  } out_item_t;

endpackage

// ===== design/ve_map_bilinear_feedback_learn.sv =====
// ----------------------------------------------------------------------------
// ve_map_bilinear_feedback_learn: adaptive fuel-map learner
// Forms a mixture correction per engine tick and spreads it bilinearly over
// up to four fuel table cells; also serves table reads and writes.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | vmbl_pkg::in_item_t
// out     | output    | out_valid_o / out_stall_i | vmbl_pkg::out_item_t
// cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One transaction at a time; the next input is taken in the cycle after the
// result leaves. An open-loop correction tick waits on the serial divider,
// and each written cell passes through the bit-serial multiply. The table RAM
// has one port; cells are updated read-modify-write in turn. Reset clears
// control and the hold-off timer; the table is undefined. The result is held
// until out_stall_i drops.
// ----------------------------------------------------------------------------
module ve_map_bilinear_feedback_learn (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  vmbl_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output vmbl_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);
  import vmbl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_CORR, S_CELL, S_RD, S_MUL, S_WR, S_DONE, S_OUT
  } state_e;

  // configuration
  logic        learn_en_q;
  logic [7:0]  ratio_lo_q, ratio_hi_q, holdoff_rl_q;
  logic [15:0] cell_min_q, cell_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_en_q <= 1'b0; ratio_lo_q <= 8'd104; ratio_hi_q <= 8'd209;
      cell_min_q <= 16'd5120; cell_max_q <= 16'd15104; holdoff_rl_q <= 8'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEARN_EN: learn_en_q   <= cfg_data_i[0];
        REG_RATIO_LO: ratio_lo_q   <= cfg_data_i[7:0];
        REG_RATIO_HI: ratio_hi_q   <= cfg_data_i[7:0];
        REG_CELL_MIN: cell_min_q   <= cfg_data_i;
        REG_CELL_MAX: cell_max_q   <= cfg_data_i;
        REG_HOLDOFF:  holdoff_rl_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // table memory: one port, registered read
  logic [15:0] table_mem [TableSize];
  logic        mem_we;
  logic [IdxW-1:0] mem_addr;
  logic [15:0] mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) table_mem[mem_addr] <= mem_wdata;
    mem_rdata_q <= table_mem[mem_addr];
  end

  // divider
  logic       div_start, div_done;
  logic [8:0] div_quot;

  vmbl_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .adc_i(in_data_i.rear_o2_adc),
    .done_o(div_done), .quot_o(div_quot)
  );

  state_e      state_q;
  in_item_t    item_q;
  out_item_t   res_q;
  logic [7:0]  hold_q;
  logic signed [15:0] d_q;
  logic [1:0]  cell_q;
  logic [3:0]  plan_q;
  logic [IdxW-1:0] base_q;
  // serial multiply: acc += w * rd, one weight bit per cycle
  logic signed [24:0] rd_q;      // row weight times d (|255*383| < 2^17)
  logic signed [33:0] acc_q;
  logic [7:0]  w_q;
  logic [3:0]  bit_q;

  logic [7:0] row, col, r1, c1, r0, c0;
  assign row = item_q.load_axis[7:0];
  assign col = item_q.rpm_axis[7:0];
  assign r1  = item_q.load_axis[15:8];
  assign c1  = item_q.rpm_axis[15:8];
  assign r0  = 8'd255 - r1;
  assign c0  = 8'd255 - c1;

  logic learn_ok, in_range, last_row, last_col;
  assign learn_ok = learn_en_q && item_q.purge_duty == 8'd0 && !item_q.fuel_cut_or_fault;
  assign in_range = row < 8'(TableRows) && col < 8'(TableCols);
  assign last_row = row >= 8'(TableRows - 1);
  assign last_col = col >= 8'(TableCols - 1);

  logic [7:0] sh, reload_val;
  assign sh         = {3'b000, item_q.rpm_code[7:3]};
  assign reload_val = (holdoff_rl_q > sh) ? holdoff_rl_q - sh : 8'd0;

  logic [IdxW-1:0] cell_addr;
  always_comb begin
    case (cell_q)
      2'd0:    cell_addr = base_q;
      2'd1:    cell_addr = base_q + IdxW'(1);
      2'd2:    cell_addr = base_q + IdxW'(TableCols);
      default: cell_addr = base_q + IdxW'(TableCols + 1);
    endcase
  end

  // delta: product / 65536 rounded toward minus infinity, which the
  // arithmetic shift gives for both signs
  logic signed [17:0] delta;
  assign delta = 18'(acc_q >>> 16);
  logic signed [18:0] newv;
  assign newv = $signed({3'b000, mem_rdata_q}) + 19'(delta);
  logic [15:0] clamped;
  always_comb begin
    if (newv < $signed({3'b000, cell_min_q}))      clamped = cell_min_q;
    else if (newv > $signed({3'b000, cell_max_q})) clamped = cell_max_q;
    else                                           clamped = newv[15:0];
  end

  assign mem_we    = (state_q == S_WR) ||
                     (state_q == S_IDLE && in_valid_i && in_data_i.req_type == REQ_WRITE &&
                      in_data_i.entry_index < 8'(TableSize));
  assign mem_addr  = (state_q == S_IDLE) ? IdxW'(in_data_i.entry_index) : cell_addr;
  assign mem_wdata = (state_q == S_IDLE) ? in_data_i.entry_value : clamped;
  assign div_start = state_q == S_IDLE && in_valid_i;

  // next cell in plan order
  function automatic logic [2:0] next_cell(input logic [3:0] p, input logic [1:0] from);
    logic [2:0] r;
    r = 3'd4;
    for (int i = 3; i >= 0; i--)
      if (p[i] && 3'(i) >= {1'b0, from}) r = 3'(i);
    return r;
  endfunction

  logic [2:0] nxt0, nxtn;
  assign nxt0 = next_cell(plan_q, 2'd0);
  assign nxtn = (cell_q == 2'd3) ? 3'd4 : next_cell(plan_q, cell_q + 2'd1);

  logic [7:0] cw;   // column weight of current cell
  logic [7:0] rw;   // row weight of current cell
  assign cw = cell_q[0] ? c1 : c0;
  assign rw = cell_q[1] ? r1 : r0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hold_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          item_q <= in_data_i;
          res_q  <= '0;
          d_q    <= '0;
          state_q <= (in_data_i.req_type == REQ_READ) ? S_RD :
                     (in_data_i.req_type == REQ_TICK) ? S_DIV : S_DONE;
        end
        S_RD: begin
          // read data of the request address is valid now
          if (item_q.entry_index < 8'(TableSize) && item_q.req_type == REQ_READ)
            res_q.read_value <= mem_rdata_q;
          state_q <= S_DONE;
        end
        S_DIV: begin
          if (!learn_ok) begin
            hold_q <= holdoff_rl_q; state_q <= S_DONE;
          end else if (hold_q != 8'd0) begin
            hold_q <= hold_q - 8'd1; state_q <= S_DONE;
          end else if (item_q.closed_loop) begin
            d_q <= 16'($signed({1'b0, item_q.o2_trim[15:8]}) - 9'sd128);
            state_q <= S_CORR;
          end else if (div_done) begin
            res_q.sensor_ratio <= div_quot;
            if (div_quot > {1'b0, ratio_lo_q} && div_quot < {1'b0, ratio_hi_q})
              d_q <= 16'($signed({8'd0, item_q.ratio_measured}) -
                         $signed({7'd0, div_quot}));
            state_q <= S_CORR;
          end
        end
        S_CORR: begin
          res_q.correction <= d_q;
          hold_q <= reload_val;
          base_q <= IdxW'(col) + IdxW'(row * 8'(TableCols));
          if (d_q != 0 && in_range) begin
            plan_q <= {(r1 != 0 && !last_row && !last_col && c1 != 0),
                       (r1 != 0 && !last_row && c0 != 0),
                       (r0 != 0 && !last_row && !last_col && c1 != 0),
                       (r0 != 0 && c0 != 0)};
            res_q.cells_updated <= {(r1 != 0 && !last_row && !last_col && c1 != 0),
                                    (r1 != 0 && !last_row && c0 != 0),
                                    (r0 != 0 && !last_row && !last_col && c1 != 0),
                                    (r0 != 0 && c0 != 0)};
            cell_q  <= 2'd0;
            state_q <= S_CELL;
          end else state_q <= S_DONE;
        end
        S_CELL: begin
          if (nxt0 == 3'd4 && cell_q == 2'd0 && !plan_q[0] && plan_q == 4'd0)
            state_q <= S_DONE;
          else begin
            if (!plan_q[cell_q]) begin
              if (nxtn == 3'd4) state_q <= S_DONE;
              else cell_q <= nxtn[1:0];
            end else begin
              rd_q  <= $signed({1'b0, rw}) * 25'(d_q);
              acc_q <= '0;
              w_q   <= cw;
              bit_q <= 4'd8;
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          // one weight bit per cycle; the table read is already in flight
          if (w_q[0]) acc_q <= acc_q + 34'(rd_q);
          rd_q  <= rd_q <<< 1;
          w_q   <= w_q >> 1;
          bit_q <= bit_q - 4'd1;
          if (bit_q == 4'd1) state_q <= S_WR;
        end
        S_WR: begin
          if (nxtn == 3'd4) state_q <= S_DONE;
          else begin
            cell_q  <= nxtn[1:0];
            state_q <= S_CELL;
          end
        end
        S_DONE: begin
          res_q.holdoff_timer <= hold_q;
          state_q <= S_OUT;
        end
        S_OUT: if (!out_stall_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = state_q == S_OUT;
  assign out_data_o  = res_q;
endmodule

// ===== design/vmbl_divider.sv =====
// ----------------------------------------------------------------------------
// vmbl_divider: bit-serial restoring divider
// Computes 32027 / (125 + adc), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vmbl_divider (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] adc_i,
  output logic       done_o,
  output logic [8:0] quot_o
);
  import vmbl_pkg::*;

  logic [15:0] num_q, num_d;
  logic [8:0]  den_q, den_d;
  logic [9:0]  rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [10:0] trial;

  assign trial = {rem_q, num_q[15]} - {2'b00, den_q};

  always_comb begin
    num_d = num_q; den_d = den_q; rem_d = rem_q; quo_d = quo_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      num_d = DivNumer; den_d = DivBias + {1'b0, adc_i};
      rem_d = '0; quo_d = '0; cnt_d = 5'd16; busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[14:0], 1'b0};
      if (!trial[10]) begin
        rem_d = trial[9:0];
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = {rem_q[8:0], num_q[15]};
        quo_d = {quo_q[14:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; den_q <= den_d; rem_q <= rem_d; quo_q <= quo_d;
  end

  // 32027/125 < 512, so the quotient fits in nine bits
  assign done_o = done_q;
  assign quot_o = quo_q[8:0];
endmodule
